// File: hdl/dfs_pkg.sv
// Shared types and character codes for the delimited field splitter.
package dfs_pkg;

    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_QUOTE = 8'd34;
    localparam logic [7:0] CH_COMMA = 8'd44;

    localparam logic [7:0] DELIM_RESET = CH_COMMA;

    // quote tracking in comma mode
    localparam logic [1:0] QP_OUT  = 2'd0;
    localparam logic [1:0] QP_IN   = 2'd1;
    localparam logic [1:0] QP_PEND = 2'd2;

    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
        logic       no_char;
    } dfs_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic [1:0] fields_closed;
        logic       line_done;
        logic       quote_error;
    } dfs_result_t;

    typedef struct packed {
        logic       in_word;
        logic [1:0] quote_phase;
        logic       error_seen;
    } dfs_state_t;

endpackage

// File: hdl/delimited_field_splitter.sv
// Top level of the delimited field splitter: input register, line state, result register.
//
// Usage:
//   Slave stream s_*: one byte per transaction. s_tdata = ch, s_tlast = line end,
//   s_tuser = no byte (the transaction only ends an empty line).
//   Master stream m_*: exactly one result transaction per input transaction.
//   m_tdata = {5'b0, fields_closed, char_valid, out_char}, m_tlast = line done,
//   m_tuser = quote error seen in this line.
//   Config channel cfg_*: writes the delimiter byte (reset value comma), which
//   also selects whitespace, comma-CSV or plain split mode. Write only while idle.
// Pipeline: an accepted input goes to the input register, its result then to the result register.
// Throughput: one transaction per cycle while m_tready is high; the line state update
// between the two registers is combinational.
// Reset: clears both pipeline valids and the line state; delimiter returns to comma.
// Stall: when m_tready is low the result register holds, the input register fills,
// and s_tready drops only once both are occupied. Nothing is lost or duplicated.
module delimited_field_splitter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,
    input  logic        s_tuser,   // [0] no_char
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] out_char, [8] char_valid, [10:9] fields_closed
    output logic        m_tlast,
    output logic        m_tuser,   // [0] quote_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data
);
    import dfs_pkg::*;

    logic        in_valid_reg;
    dfs_item_t   in_item_reg;
    logic        out_valid_reg;
    dfs_result_t out_res_reg;
    dfs_state_t  state_reg;
    dfs_state_t  state_next;
    dfs_result_t step_res;
    logic [7:0]  delim_reg;
    logic        advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    dfs_step u_step (
        .delimiter  (delim_reg),
        .item       (in_item_reg),
        .state      (state_reg),
        .result     (step_res),
        .state_next (state_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            delim_reg     <= DELIM_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                delim_reg <= cfg_data;
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.ch       <= s_tdata;
            in_item_reg.line_end <= s_tlast;
            in_item_reg.no_char  <= s_tuser;
        end
        if (advance)
            out_res_reg <= step_res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg.fields_closed, out_res_reg.char_valid,
                       out_res_reg.out_char};
    assign m_tlast  = out_res_reg.line_done;
    assign m_tuser  = out_res_reg.quote_error;

    // line state is cleared after every line end
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_item_reg.line_end) |=> (state_reg == '0))
        else $error("line state not cleared after line end");

    // a line with a quote error closes no fields from then on
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[10:9] == 2'd0))
        else $error("field closed while quote error set");

    // at most two fields close per item
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:9] != 2'd3))
        else $error("fields_closed out of range");

    // no byte is reported unless it belongs to a field
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[8]) |-> (m_tdata[7:0] == 8'd0))
        else $error("out_char nonzero without char_valid");

endmodule

// File: hdl/dfs_step.sv
// Per-byte tokenizer logic: result and next line state for one item.
module dfs_step (
    input  logic [7:0]          delimiter,
    input  dfs_pkg::dfs_item_t  item,
    input  dfs_pkg::dfs_state_t state,
    output dfs_pkg::dfs_result_t result,
    output dfs_pkg::dfs_state_t state_next
);
    import dfs_pkg::*;

    logic ws_mode;
    logic csv_mode;
    logic blank;

    assign ws_mode  = (delimiter == CH_SPACE) || ((delimiter >= CH_LF) && (delimiter <= CH_CR));
    assign csv_mode = (delimiter == CH_COMMA);
    assign blank    = (item.ch == CH_SPACE) || ((item.ch >= CH_TAB) && (item.ch <= CH_CR));

    always_comb
    begin
        state_next = state;
        result     = '0;

        if (!item.no_char && !state.error_seen)
        begin
            if (ws_mode)
            begin
                if (blank)
                begin
                    if (state.in_word)
                    begin
                        result.fields_closed = 2'd1;
                        state_next.in_word   = 1'b0;
                    end
                end
                else
                begin
                    result.out_char    = item.ch;
                    result.char_valid  = 1'b1;
                    state_next.in_word = 1'b1;
                end
            end
            else if (csv_mode)
            begin
                case (state.quote_phase)
                    QP_OUT:
                    begin
                        if (item.ch == CH_QUOTE)
                            state_next.quote_phase = QP_IN;
                        else if (item.ch == CH_COMMA)
                            result.fields_closed = 2'd1;
                        else
                        begin
                            result.out_char   = item.ch;
                            result.char_valid = 1'b1;
                        end
                    end
                    QP_PEND:
                    begin
                        if (item.ch == CH_QUOTE)
                        begin
                            // doubled quote is a literal quote
                            result.out_char        = item.ch;
                            result.char_valid      = 1'b1;
                            state_next.quote_phase = QP_IN;
                        end
                        else if (item.ch == CH_COMMA)
                        begin
                            result.fields_closed   = 2'd1;
                            state_next.quote_phase = QP_OUT;
                        end
                        else
                            state_next.error_seen = 1'b1;
                    end
                    default:
                    begin
                        if (item.ch == CH_QUOTE)
                            state_next.quote_phase = QP_PEND;
                        else
                        begin
                            result.out_char   = item.ch;
                            result.char_valid = 1'b1;
                        end
                    end
                endcase
            end
            else
            begin
                if (item.ch == delimiter)
                    result.fields_closed = 2'd1;
                else
                begin
                    result.out_char   = item.ch;
                    result.char_valid = 1'b1;
                end
            end
        end

        if (item.line_end)
        begin
            result.line_done = 1'b1;
            if (!state_next.error_seen)
            begin
                if (ws_mode)
                begin
                    if (state_next.in_word)
                        result.fields_closed = result.fields_closed + 2'd1;
                end
                else if (csv_mode)
                begin
                    if ((state_next.quote_phase == QP_OUT) || (state_next.quote_phase == QP_PEND))
                        result.fields_closed = result.fields_closed + 2'd1;
                    else
                        state_next.error_seen = 1'b1;
                end
                else
                    result.fields_closed = result.fields_closed + 2'd1;
            end
        end

        result.quote_error = state_next.error_seen;

        if (item.line_end)
            state_next = '0;
    end

endmodule
